// ===== rtl/fcr_pkg.sv =====
// Shared types and constants of the frequency clock replacement directory.
`default_nettype none

package fcr_pkg;

  // Fixed field widths
  localparam int KEY_BITS  = 32;
  localparam int SLOT_BITS = 4;
  localparam int CAP_BITS  = 5;

  // Stream payload widths (packed, zero filled to whole bytes)
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_CAPACITY = 3'd0;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_WALK
  } fcr_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // capture the incoming key
    logic upd_hit;  // bump the hit entry's counter and post the result
    logic fill;     // place the key in the next unused slot
    logic age;      // decrement the entry under the hand and advance
    logic evict;    // replace the entry under the hand
  } fcr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hit;       // key found in a valid slot
    logic room;      // an unused slot is left within capacity
    logic victim;    // entry under the hand may be evicted
    logic out_free;  // result register can take a new result
  } fcr_status_t;

endpackage

`default_nettype wire

// ===== rtl/fcr_ctrl.sv =====
// Controller state machine: sequences lookup, fill, aging walk and eviction.
`default_nettype none

module fcr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire fcr_pkg::fcr_status_t status,
  output fcr_pkg::fcr_cmd_t        cmd
);
  import fcr_pkg::*;

  fcr_state_t state;
  fcr_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_MATCH;
        end
      end
      ST_MATCH: begin
        // Commit only when the result register can take the result
        if (status.hit) begin
          if (status.out_free) begin
            cmd.upd_hit = 1'b1;
            state_next  = ST_IDLE;
          end
        end else if (status.room) begin
          if (status.out_free) begin
            cmd.fill   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status.victim) begin
          if (status.out_free) begin
            cmd.evict  = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.age = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/fcr_datapath.sv =====
// Datapath: slot storage, parallel key match, hand, fill count and result register.
`default_nettype none

module fcr_datapath #(
  parameter int ENTRIES   = 16,
  parameter int COUNT_MAX = 7
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic [fcr_pkg::KEY_BITS-1:0]                  key_in,
  input  wire logic [((ENTRIES + 1 > 32) ? $clog2(ENTRIES + 1) : 5)-1:0] cap_eff,
  input  wire fcr_pkg::fcr_cmd_t                             cmd,
  output fcr_pkg::fcr_status_t                               status,
  output logic                                               out_valid,
  input  wire logic                                          out_ready,
  output logic                                               res_hit,
  output logic                                               res_evicted,
  output logic [fcr_pkg::KEY_BITS-1:0]                       res_evicted_key,
  output logic [fcr_pkg::SLOT_BITS-1:0]                      res_slot
);
  import fcr_pkg::*;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam int CW     = (ENTRIES + 1 > 32) ? $clog2(ENTRIES + 1) : 5;
  localparam int CNT_W  = $clog2(COUNT_MAX + 1);

  logic [KEY_BITS-1:0] keys [ENTRIES];
  logic                valid [ENTRIES];
  logic [CNT_W-1:0]    counts [ENTRIES];
  logic [IDX_W-1:0]    hand;
  logic [FILL_W-1:0]   fill_count;
  logic [KEY_BITS-1:0] key_q;

  logic [ENTRIES-1:0]  match;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    hand_eff;
  logic [IDX_W-1:0]    hand_adv;
  logic [IDX_W-1:0]    fill_idx;
  logic [FILL_W-1:0]   hand_plus;
  logic [IDX_W+SLOT_BITS-1:0] hit_slot_ext;
  logic [IDX_W+SLOT_BITS-1:0] fill_slot_ext;
  logic [IDX_W+SLOT_BITS-1:0] hand_slot_ext;
  logic                commit;

  // Compare the key against every valid slot at once
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid[i] && (keys[i] == key_q);
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  // Hand restarts at slot zero when outside the filled slots
  always_comb begin
    hand_eff  = (FILL_W'(hand) >= fill_count) ? '0 : hand;
    hand_plus = FILL_W'(hand_eff) + FILL_W'(1);
    hand_adv  = (hand_plus < fill_count) ? hand_plus[IDX_W-1:0] : '0;
    fill_idx  = fill_count[IDX_W-1:0];
  end

  // Slot numbers as reported on the result
  assign hit_slot_ext  = {{SLOT_BITS{1'b0}}, hit_idx};
  assign fill_slot_ext = {{SLOT_BITS{1'b0}}, fill_idx};
  assign hand_slot_ext = {{SLOT_BITS{1'b0}}, hand_eff};

  assign commit = cmd.upd_hit | cmd.fill | cmd.evict;

  // Status toward the controller
  always_comb begin
    status.hit      = |match;
    status.room     = CW'(fill_count) < cap_eff;
    status.victim   = counts[hand_eff] <= CNT_W'(1);
    status.out_free = !out_valid || out_ready;
  end

  // Capture the requested key
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q <= key_in;
    end
  end

  // Slot keys carry no reset; valid bits guard them
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      keys[fill_idx] <= key_q;
    end else if (cmd.evict) begin
      keys[hand_eff] <= key_q;
    end
  end

  // Valid bits, counters, hand and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i]  <= 1'b0;
        counts[i] <= '0;
      end
      hand       <= '0;
      fill_count <= '0;
    end else begin
      if (cmd.upd_hit) begin
        if (counts[hit_idx] < CNT_W'(COUNT_MAX)) begin
          counts[hit_idx] <= counts[hit_idx] + CNT_W'(1);
        end
      end
      if (cmd.fill) begin
        valid[fill_idx]  <= 1'b1;
        counts[fill_idx] <= CNT_W'(1);
        fill_count       <= fill_count + FILL_W'(1);
      end
      if (cmd.age) begin
        counts[hand_eff] <= counts[hand_eff] - CNT_W'(1);
        hand             <= hand_adv;
      end
      if (cmd.evict) begin
        valid[hand_eff]  <= 1'b1;
        counts[hand_eff] <= CNT_W'(1);
        hand             <= hand_adv;
      end
    end
  end

  // Result register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_hit) begin
      res_hit         <= 1'b1;
      res_evicted     <= 1'b0;
      res_evicted_key <= '0;
      res_slot        <= hit_slot_ext[SLOT_BITS-1:0];
    end else if (cmd.fill) begin
      res_hit         <= 1'b0;
      res_evicted     <= 1'b0;
      res_evicted_key <= '0;
      res_slot        <= fill_slot_ext[SLOT_BITS-1:0];
    end else if (cmd.evict) begin
      res_hit         <= 1'b0;
      res_evicted     <= 1'b1;
      res_evicted_key <= keys[hand_eff];
      res_slot        <= hand_slot_ext[SLOT_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/frequency_clock_replacement.sv =====
// Top level: frequency-counting clock replacement directory with stream and APB ports.
//
// Fully associative directory of ENTRIES keys with saturating access counters
// (1..COUNT_MAX). Each key on the input stream yields one result: hit, evicted,
// the evicted key (zero when none) and the slot that holds the key afterwards.
// A hit or a fill into an unused slot takes the key in the idle state, then
// does the parallel match and the update in the match state. A miss with the
// directory full goes on to the walk state, where the hand ages one entry at a
// time from its current position until it finds an entry that it may evict.
// Each commit waits until the result register can take the result. The next key
// is taken while a finished result still waits on the output. The capacity
// register (byte address 0, bits 4:0) limits the number of slots that fills
// may take; zero acts as one, values above ENTRIES as ENTRIES, and its reset
// value is ENTRIES.
`default_nettype none

module frequency_clock_replacement #(
  parameter int ENTRIES   = 16,
  parameter int COUNT_MAX = 7
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // tdata: key[31:0]
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [fcr_pkg::IN_DATA_W-1:0]    s_tdata,
  // tdata: hit[0], evicted[1], evicted_key[33:2], slot[37:34], zero[39:38]
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [fcr_pkg::OUT_DATA_W-1:0]        m_tdata,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [fcr_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [fcr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [fcr_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);
  import fcr_pkg::*;

  localparam int CW = (ENTRIES + 1 > 32) ? $clog2(ENTRIES + 1) : 5;

  logic [CW-1:0]         capacity;
  logic [CW-1:0]         cap_eff;
  logic                  cfg_wr;
  logic                  cap_sel;
  fcr_cmd_t              cmd;
  fcr_status_t           status;
  logic                  res_hit;
  logic                  res_evicted;
  logic [KEY_BITS-1:0]   res_evicted_key;
  logic [SLOT_BITS-1:0]  res_slot;

  // Configuration register access
  assign pready  = 1'b1;
  assign cap_sel = (paddr[2:2] == REG_CAPACITY[2:2]);
  assign cfg_wr  = psel && penable && pwrite && pready && cap_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CW'(ENTRIES);
    end else if (cfg_wr) begin
      capacity <= CW'(pwdata[CAP_BITS-1:0]);
    end
  end

  assign prdata = cap_sel ? APB_DATA_W'(capacity) : '0;

  // Clamp capacity into one..ENTRIES
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (capacity > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = capacity;
    end
  end

  fcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fcr_datapath #(
    .ENTRIES   (ENTRIES),
    .COUNT_MAX (COUNT_MAX)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .key_in          (s_tdata[KEY_BITS-1:0]),
    .cap_eff         (cap_eff),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .res_hit         (res_hit),
    .res_evicted     (res_evicted),
    .res_evicted_key (res_evicted_key),
    .res_slot        (res_slot)
  );

  // Pack the result fields
  assign m_tdata = {2'b00, res_slot, res_evicted_key, res_evicted, res_hit};

  // A hit never evicts
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("hit and eviction reported together");

  // No eviction means a zero evicted key
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[1]) |-> (m_tdata[33:2] == '0))
    else $error("evicted key set without eviction");

  // One key at a time: a transfer in closes the input until the result is posted
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a key is in work");

  // Datapath commands never overlap
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.upd_hit, cmd.fill, cmd.age, cmd.evict}))
    else $error("overlapping datapath commands");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the frequency clock replacement directory.
module tb_top;

  localparam int ENTRIES      = 16;
  localparam int COUNT_MAX    = 7;
  localparam int RANDOM_ITEMS = 650;
  localparam int DRAIN_CYCLES = 120;
  localparam int LIMIT_CYCLES = 600000;

  // One lookup outcome as the block reports it
  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [31:0] evicted_key;
    logic [3:0]  slot;
  } lookup_result_t;

  // Directory shadow: predicts each lookup and holds the outcomes still due
  class directory_scoreboard;
    logic [31:0]    keys [ENTRIES];
    bit             valid [ENTRIES];
    bit [2:0]       counts [ENTRIES];
    bit [3:0]       hand;
    bit [4:0]       fill;
    bit [4:0]       capacity;
    lookup_result_t pending [$];
    int             errors;
    int             requests;
    int             hits;
    int             evictions;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        keys[i]   = '0;
        valid[i]  = 1'b0;
        counts[i] = '0;
      end
      hand      = '0;
      fill      = '0;
      capacity  = 5'(ENTRIES);
      errors    = 0;
      requests  = 0;
      hits      = 0;
      evictions = 0;
    endfunction

    function void set_capacity(logic [31:0] value);
      capacity = value[4:0];
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    // Advance the hand around the filled slots
    function bit [3:0] next_slot(bit [3:0] s);
      return (int'(s) + 1 < int'(fill)) ? s + 4'd1 : 4'd0;
    endfunction

    // Apply one lookup to the shadow and queue its outcome
    function void note_request(logic [31:0] key);
      lookup_result_t r;
      int             cap;
      int             pos;
      bit             found;
      r     = '0;
      pos   = 0;
      found = 1'b0;
      cap   = (capacity == 0) ? 1 : ((int'(capacity) > ENTRIES) ? ENTRIES : int'(capacity));
      for (int i = 0; i < ENTRIES && !found; i++) begin
        if (valid[i] && keys[i] == key) begin
          found = 1'b1;
          pos   = i;
        end
      end
      if (found) begin
        if (counts[pos] < COUNT_MAX) counts[pos]++;
        r.hit = 1'b1;
        hits++;
      end else if (int'(fill) < cap) begin
        pos         = int'(fill);
        keys[pos]   = key;
        valid[pos]  = 1'b1;
        counts[pos] = 3'd1;
        fill++;
      end else begin
        // age entries from the hand until one with count one turns up
        if (int'(hand) >= int'(fill)) hand = '0;
        while (counts[hand] > 1) begin
          counts[hand]--;
          hand = next_slot(hand);
        end
        pos           = int'(hand);
        r.evicted     = 1'b1;
        r.evicted_key = keys[pos];
        keys[pos]     = key;
        valid[pos]    = 1'b1;
        counts[pos]   = 3'd1;
        hand          = next_slot(hand);
        evictions++;
      end
      r.slot = pos[3:0];
      pending.push_back(r);
      requests++;
    endfunction

    // Compare one output transfer with the oldest outcome due
    function void check_response(logic [fcr_pkg::OUT_DATA_W-1:0] data);
      lookup_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result %h arrived with no request pending", $time, data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (data[0] !== want.hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, want.hit, data[0]);
        errors++;
      end
      if (data[1] !== want.evicted) begin
        $display("%0t: evicted expected %0d actual %0d", $time, want.evicted, data[1]);
        errors++;
      end
      if (data[33:2] !== want.evicted_key) begin
        $display("%0t: evicted_key expected %h actual %h", $time, want.evicted_key,
                 data[33:2]);
        errors++;
      end
      if (data[37:34] !== want.slot) begin
        $display("%0t: slot expected %0d actual %0d", $time, want.slot, data[37:34]);
        errors++;
      end
      if (data[39:38] !== 2'b00) begin
        $display("%0t: pad bits expected 0 actual %b", $time, data[39:38]);
        errors++;
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst      = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [fcr_pkg::IN_DATA_W-1:0]     s_tdata  = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [fcr_pkg::OUT_DATA_W-1:0]    m_tdata;
  logic                              psel     = 1'b0;
  logic                              penable  = 1'b0;
  logic                              pwrite   = 1'b0;
  logic [fcr_pkg::APB_ADDR_W-1:0]    paddr    = '0;
  logic [fcr_pkg::APB_DATA_W-1:0]    pwdata   = '0;
  logic [fcr_pkg::APB_DATA_W-1:0]    prdata;
  logic                              pready;

  directory_scoreboard sb = new();
  bit          quiet        = 1'b0;
  int          cycle_count  = 0;
  int          stall_left   = 0;
  int          config_count = 0;
  logic [31:0] key_pool [$];

  frequency_clock_replacement #(
    .ENTRIES   (ENTRIES),
    .COUNT_MAX (COUNT_MAX)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short idle stretches, a few long ones
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 50) return 0;
    if (p < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result side at random
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 20) stall_left <= pick_gap();
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_response(m_tdata);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("frequency_clock_replacement test failed");
      $finish;
    end
  end

  // Offer one key after a random gap and hold it until the transfer
  task automatic send_key(logic [31:0] key);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    do @(posedge clk); while (!s_tready);
    sb.note_request(key);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // Write the capacity register, then read it back
  task automatic write_capacity(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= fcr_pkg::REG_CAPACITY;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_capacity(value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[4:0] !== value[4:0]) begin
      $display("%0t: capacity read expected %0d actual %0d", $time, value[4:0], prdata[4:0]);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    config_count++;
  endtask

  // Build a working set of keys so that lookups hit and evict
  task automatic refill_pool(int size);
    key_pool.delete();
    for (int i = 0; i < size; i++) begin
      case ($urandom_range(0, 15))
        0:       key_pool.push_back(32'h0000_0000);
        1:       key_pool.push_back(32'hFFFF_FFFF);
        default: key_pool.push_back($urandom());
      endcase
    end
  endtask

  initial begin
    logic [31:0] warm_keys [11];
    int          sent;
    int          phase_len;
    int          cap_sel;
    int          eff_cap;
    logic [31:0] cap_value;

    warm_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                  32'h0000_0000, 32'h0000_0000, 32'h0000_0000};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset capacity: fill, then saturate one counter and push past the top
    quiet = 1'b1;
    foreach (warm_keys[i]) send_key(warm_keys[i]);
    wait_idle();

    // Capacity below the fill level: evict inside the filled slots
    write_capacity(32'd2);
    send_key(32'h1234_5678);
    send_key(32'h0000_0001);
    send_key(32'h8000_0000);
    wait_idle();

    // Capacity zero acts as one
    write_capacity(32'd0);
    send_key(32'hFFFF_0000);
    send_key(32'h0000_FFFF);
    wait_idle();

    // Capacity above the slot count acts as full size; fill fresh slots
    write_capacity(32'd31);
    send_key(32'h0F0F_0F0F);
    send_key(32'hF0F0_F0F0);
    send_key(32'h0000_0000);
    wait_idle();

    // Random phases over a spread of capacity settings
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      cap_sel = $urandom_range(0, 9);
      case (cap_sel)
        0:       cap_value = 32'd0;
        1:       cap_value = 32'd1;
        2:       cap_value = 32'd16;
        3:       cap_value = 32'd31;
        default: cap_value = $urandom_range(2, 15);
      endcase
      if ($urandom_range(0, 3) == 0) cap_value = ($urandom() & ~32'h1F) | cap_value;
      write_capacity(cap_value);
      eff_cap = (cap_value[4:0] == 0) ? 1 :
                ((int'(cap_value[4:0]) > ENTRIES) ? ENTRIES : int'(cap_value[4:0]));
      refill_pool(eff_cap + $urandom_range(0, eff_cap + 3));
      quiet     = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 70);
      for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 75)
          send_key(key_pool[$urandom_range(0, key_pool.size() - 1)]);
        else
          send_key($urandom());
        sent++;
      end
      wait_idle();
    end

    // Let any late or extra result show up
    quiet = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.outstanding());
      sb.errors++;
    end

    $display("Covered %0d lookups (%0d hits, %0d evictions) across %0d capacity writes.",
             sb.requests, sb.hits, sb.evictions, config_count);
    $display("Mismatches found: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("frequency_clock_replacement test passed");
    end else begin
      $display("frequency_clock_replacement test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fcr_pkg.sv
rtl/fcr_ctrl.sv
rtl/fcr_datapath.sv
rtl/frequency_clock_replacement.sv
tb/sv/tb_top.sv
